FILE: rtl/core/mlcd_pkg.sv
// Shared types and constants for the memory LCD frame store and line framer.
// No dependencies; imported by mlcd_ctrl, mlcd_dp and the core top.
`timescale 1ns / 1ps

package mlcd_pkg;

    // Screen geometry
    localparam int WIDTH_PIXELS = 72;
    localparam int HEIGHT_LINES = 144;
    localparam int LINE_BYTES   = (WIDTH_PIXELS + 1) / 2;
    localparam int STORE_BYTES  = LINE_BYTES * HEIGHT_LINES;
    localparam int PKT_BYTES    = LINE_BYTES + 4;

    // Widths
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int XC_W   = $clog2(WIDTH_PIXELS + 1);
    localparam int YC_W   = $clog2(HEIGHT_LINES + 1);
    localparam int BC_W   = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int CNT_W  = $clog2(PKT_BYTES);
    localparam int CW     = 11;     // signed work width for clipping math

    // Packet header bytes
    localparam logic [7:0] HDR_UPDATE    = 8'h90;
    localparam logic [7:0] HDR_VCOM      = 8'h40;
    localparam logic [7:0] HDR_ALL_CLEAR = 8'h20;
    localparam logic [7:0] HDR_NO_UPDATE = 8'h00;

    typedef enum logic [2:0] {
        FN_SET_PIXEL   = 3'd0,
        FN_FILL_RECT   = 3'd1,
        FN_FILL_SCREEN = 3'd2,
        FN_SEND_LINE   = 3'd3,
        FN_TOGGLE_VCOM = 3'd4,
        FN_ALL_CLEAR   = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SWEEP,
        OP_RECT_RD,
        OP_RECT_WR,
        OP_LINE,
        OP_PAIR_HDR,
        OP_PAIR_TAIL
    } t_dp_op;

    typedef struct packed {
        t_func func;
        logic  rect_empty;
        logic  rect_last;
        logic  line_ok;
        logic  line_done;
        logic  sweep_last;
    } t_dp_stat;

endpackage

FILE: rtl/core/mlcd_ram.sv
// Generic single-port RAM, registered read, read-first.
// No dependencies.
`timescale 1ns / 1ps

module mlcd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_W-1:0]        i_wdata,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/mlcd_ctrl.sv
// Command sequencer: decides which datapath operation runs each cycle.
// Depends on mlcd_pkg.
`timescale 1ns / 1ps

module mlcd_ctrl
    import mlcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op,
    output logic     o_busy
);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_DISPATCH,
        S_RECT_RD,
        S_RECT_WR,
        S_LINE,
        S_PAIR_HDR,
        S_PAIR_TAIL
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NOP;
        unique case (r_state)
            S_SWEEP: begin
                o_op = OP_SWEEP;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_op    = OP_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.func)
                    FN_SET_PIXEL, FN_FILL_RECT: begin
                        n_state = i_stat.rect_empty ? S_IDLE : S_RECT_RD;
                    end
                    FN_FILL_SCREEN: n_state = S_SWEEP;
                    FN_SEND_LINE:   n_state = i_stat.line_ok ? S_LINE : S_IDLE;
                    FN_TOGGLE_VCOM, FN_ALL_CLEAR: n_state = S_PAIR_HDR;
                    default:        n_state = S_IDLE;
                endcase
            end
            S_RECT_RD: begin
                o_op    = OP_RECT_RD;
                n_state = S_RECT_WR;
            end
            S_RECT_WR: begin
                o_op    = OP_RECT_WR;
                n_state = i_stat.rect_last ? S_IDLE : S_RECT_RD;
            end
            S_LINE: begin
                o_op = OP_LINE;
                if (i_stat.line_done) begin
                    n_state = S_IDLE;
                end
            end
            S_PAIR_HDR: begin
                o_op    = OP_PAIR_HDR;
                n_state = S_PAIR_TAIL;
            end
            S_PAIR_TAIL: begin
                o_op    = OP_PAIR_TAIL;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/core/mlcd_dp.sv
// Datapath: clipping math, frame store, byte walkers and output register.
// Depends on mlcd_pkg and mlcd_ram.
`timescale 1ns / 1ps

module mlcd_dp
    import mlcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_op      i_op,
    input  logic [2:0]  i_func,
    input  logic [8:0]  i_x_pos,
    input  logic [8:0]  i_y_pos,
    input  logic [7:0]  i_rect_width,
    input  logic [7:0]  i_rect_height,
    input  logic [3:0]  i_color,
    output t_dp_stat    o_stat,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic        o_valid
);

    // command fields held for the whole operation
    t_func              r_func;
    logic [3:0]         r_color;
    logic               r_vcom;
    logic [7:0]         r_fill;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_row_base;
    logic [BC_W-1:0]    r_bcol;
    logic [BC_W-1:0]    r_bcol_start;
    logic [BC_W-1:0]    r_bcol_end;
    logic [XC_W-1:0]    r_x0;
    logic [XC_W-1:0]    r_x1;
    logic [YC_W-1:0]    r_y;
    logic [YC_W-1:0]    r_y_end;
    logic               r_rect_empty;
    logic               r_line_ok;
    logic [7:0]         r_line_num;
    logic [CNT_W-1:0]   r_cnt;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               r_out_valid;

    // clipping on the incoming command
    t_func                  in_func;
    logic                   is_pixel;
    logic signed [CW-1:0]   xs, ys, xe, ye;
    logic signed [CW-1:0]   x0c, x1c, y0c, y1c;
    logic signed [CW-1:0]   x1m1, y1m1;
    logic                   empty_c;
    logic                   line_ok_c;
    logic [ADDR_W+YC_W-1:0] base_full;

    // frame store access
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_addr;
    logic [7:0]             ram_wdata;
    logic [7:0]             ram_rdata;
    logic [XC_W:0]          col_even, col_odd, x0_ext, x1_ext;
    logic                   hi_on, lo_on;
    logic                   row_end;
    logic [7:0]             vcom_bits;

    always_comb begin
        in_func  = t_func'(i_func);
        is_pixel = (in_func == FN_SET_PIXEL);
        xs = CW'($signed(i_x_pos));
        ys = CW'($signed(i_y_pos));
        // set pixel is a 1x1 rectangle: clipping then drops it off screen
        xe = xs + (is_pixel ? CW'(1) : $signed({3'b000, i_rect_width}));
        ye = ys + (is_pixel ? CW'(1) : $signed({3'b000, i_rect_height}));
        x0c = xs[CW-1] ? '0 : xs;
        y0c = ys[CW-1] ? '0 : ys;
        x1c = (xe > $signed(CW'(WIDTH_PIXELS))) ? $signed(CW'(WIDTH_PIXELS)) : xe;
        y1c = (ye > $signed(CW'(HEIGHT_LINES))) ? $signed(CW'(HEIGHT_LINES)) : ye;
        x1m1 = x1c - CW'(1);
        y1m1 = y1c - CW'(1);
        empty_c   = (x1c <= x0c) || (y1c <= y0c);
        line_ok_c = !ys[CW-1] && (ys < $signed(CW'(HEIGHT_LINES)));
        base_full = (ADDR_W+YC_W)'(y0c[YC_W-1:0]) * (ADDR_W+YC_W)'(LINE_BYTES);
    end

    always_comb begin
        col_even = (XC_W+1)'({r_bcol, 1'b0});
        col_odd  = (XC_W+1)'({r_bcol, 1'b1});
        x0_ext   = (XC_W+1)'(r_x0);
        x1_ext   = (XC_W+1)'(r_x1);
        hi_on    = (col_even >= x0_ext);
        lo_on    = (col_odd >= x0_ext) && (col_odd < x1_ext);
        row_end  = (r_bcol == r_bcol_end);
        vcom_bits = r_vcom ? HDR_VCOM : 8'h00;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_row_base + ADDR_W'(r_bcol);
        ram_wdata = {hi_on ? r_color : ram_rdata[7:4], lo_on ? r_color : ram_rdata[3:0]};
        unique case (i_op)
            OP_SWEEP: begin
                ram_we    = 1'b1;
                ram_addr  = r_addr;
                ram_wdata = r_fill;
            end
            OP_RECT_WR: ram_we = 1'b1;
            default: ram_we = 1'b0;
        endcase
    end

    mlcd_ram #(
        .DATA_W (8),
        .DEPTH  (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // control-like state: reset clears it, reset sweep writes r_fill = 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_fill      <= '0;
            r_vcom      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (i_op == OP_LINE) || (i_op == OP_PAIR_HDR) ||
                           (i_op == OP_PAIR_TAIL);
            if (i_op == OP_SWEEP) begin
                r_addr <= r_addr + ADDR_W'(1);
            end
            if (i_op == OP_LOAD) begin
                if (in_func == FN_FILL_SCREEN) begin
                    r_addr <= '0;
                    r_fill <= {i_color, i_color};
                end
                if (in_func == FN_TOGGLE_VCOM) begin
                    r_vcom <= ~r_vcom;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: begin
                r_func       <= in_func;
                r_color      <= i_color;
                r_x0         <= x0c[XC_W-1:0];
                r_x1         <= x1c[XC_W-1:0];
                r_y          <= y0c[YC_W-1:0];
                r_y_end      <= y1m1[YC_W-1:0];
                r_bcol_start <= x0c[BC_W:1];
                r_bcol_end   <= x1m1[BC_W:1];
                r_bcol       <= (in_func == FN_SEND_LINE) ? '0 : x0c[BC_W:1];
                r_row_base   <= base_full[ADDR_W-1:0];
                r_rect_empty <= empty_c;
                r_line_ok    <= line_ok_c;
                r_line_num   <= i_y_pos[7:0] + 8'd1;
                r_cnt        <= '0;
            end
            OP_RECT_WR: begin
                if (row_end) begin
                    r_bcol     <= r_bcol_start;
                    r_y        <= r_y + YC_W'(1);
                    r_row_base <= r_row_base + ADDR_W'(LINE_BYTES);
                end else begin
                    r_bcol <= r_bcol + BC_W'(1);
                end
            end
            OP_LINE: begin
                r_cnt <= r_cnt + CNT_W'(1);
                // read address runs one byte ahead of the output register
                if (r_cnt != '0 && r_cnt < CNT_W'(LINE_BYTES)) begin
                    r_bcol <= r_bcol + BC_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        r_out_last <= 1'b0;
        unique case (i_op)
            OP_LINE: begin
                priority if (r_cnt == CNT_W'(0)) begin
                    r_out_byte <= HDR_UPDATE | vcom_bits;
                end else if (r_cnt == CNT_W'(1)) begin
                    r_out_byte <= r_line_num;
                end else if (r_cnt <= CNT_W'(LINE_BYTES + 1)) begin
                    r_out_byte <= ram_rdata;
                end else begin
                    r_out_byte <= 8'h00;
                end
                r_out_last <= (r_cnt == CNT_W'(PKT_BYTES - 1));
            end
            OP_PAIR_HDR: begin
                r_out_byte <= ((r_func == FN_ALL_CLEAR) ? HDR_ALL_CLEAR : HDR_NO_UPDATE)
                              | vcom_bits;
            end
            OP_PAIR_TAIL: begin
                r_out_byte <= 8'h00;
                r_out_last <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.func       = r_func;
        o_stat.rect_empty = r_rect_empty;
        o_stat.rect_last  = row_end && (r_y == r_y_end);
        o_stat.line_ok    = r_line_ok;
        o_stat.line_done  = (r_cnt == CNT_W'(PKT_BYTES - 1));
        o_stat.sweep_last = (r_addr == ADDR_W'(STORE_BYTES - 1));
    end

    assign o_out_byte = r_out_byte;
    assign o_last     = r_out_last & r_out_valid;
    assign o_valid    = r_out_valid;

endmodule

FILE: rtl/core/memory_lcd_frame_store_line_framer_core.sv
// Reset: synchronous, active low; afterwards busy stays high while the
// frame store is swept to black, and vcom starts at 0. One command at a time.
// Busy after a transfer: set pixel and fill rect read, merge and write each
// touched byte (read-modify-write on one RAM port); fill screen sweeps the store;
// vcom/all clear send two bytes; send line 40 bytes, one per cycle; an off-screen
// pixel, bad line index or spare code is dropped. Receiver cannot stall o_valid.
`timescale 1ns / 1ps

module memory_lcd_frame_store_line_framer_core
    import mlcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [8:0]  i_x_pos,
    input  logic [8:0]  i_y_pos,
    input  logic [7:0]  i_rect_width,
    input  logic [7:0]  i_rect_height,
    input  logic [3:0]  i_color,
    output logic [7:0]  o_out_byte,
    output logic        o_last,
    output logic        o_valid
);

    // Controller steps through one command; the datapath holds the clipped
    // rectangle, the frame store RAM and the output byte register.
    t_dp_op   dp_op;
    t_dp_stat dp_stat;

    mlcd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_op    (dp_op),
        .o_busy  (busy)
    );

    // Byte-granular walks: each rect byte is read, merged by nibble, written.
    // Line packets read one byte ahead so the RAM latency is hidden.
    mlcd_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (dp_op),
        .i_func        (i_func),
        .i_x_pos       (i_x_pos),
        .i_y_pos       (i_y_pos),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_color       (i_color),
        .o_stat        (dp_stat),
        .o_out_byte    (o_out_byte),
        .o_last        (o_last),
        .o_valid       (o_valid)
    );

    // A transfer always raises busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    // Result bytes only follow cycles in which a command was running.
    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a running command");

    // The last flag ends a packet, and the block is already idle when it shows.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> (o_valid && !busy))
        else $error("packet end seen while still busy");

endmodule
